// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent checks used by the RTL; empty when NO_ASSERTIONS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define ASSERT_NORST(label, clk, prop) \
	label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NORST(label, clk, prop)
`endif
`endif

// ----- rtl/rme_pkg.sv -----
// ---------------------------------------------------------------------------
// rme_pkg
// Shared constants and types for the rotation matrix to Euler angle block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package rme_pkg;
	localparam int CordicSteps = 16;
	localparam int NSteps = (CordicSteps > 24) ? 24 : CordicSteps;
	localparam int CW = 34;
	localparam int ZW = 32;
	localparam logic signed [ZW-1:0] AngPiQ28 = 32'sd843314857;
	localparam logic signed [15:0] HalfPiQ13 = 16'sd12868;
	localparam logic signed [15:0] PiQ13 = 16'sd25736;
	localparam logic [14:0] ThrReset = 15'd16351;
	localparam int SqrtSteps = 15;

	typedef enum logic [1:0] {
		POLE_NONE  = 2'd0,
		POLE_NORTH = 2'd1,
		POLE_SOUTH = 2'd2
	} pole_t;

	typedef struct packed {
		logic signed [CW-1:0] cx;
		logic signed [CW-1:0] cy;
		logic signed [ZW-1:0] z;
		logic                 zero;
	} cordic_t;

	function automatic logic signed [ZW-1:0] atan_step(input int i);
		logic signed [ZW-1:0] r;
		r = '0;
		case (i)
			0: r = 32'sd210828714;
			1: r = 32'sd124459456;
			2: r = 32'sd65760959;
			3: r = 32'sd33381290;
			4: r = 32'sd16755421;
			5: r = 32'sd8385879;
			6: r = 32'sd4193963;
			7: r = 32'sd2097109;
			8: r = 32'sd1048571;
			9: r = 32'sd524287;
			default: r = ZW'(64'sd1 <<< (28 - i));
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

// ----- rtl/rme_cordic.sv -----
// ---------------------------------------------------------------------------
// rme_cordic
// Pipelined vectoring CORDIC: atan2(y, x) in Q3.13 from Q1.14 operands.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module rme_cordic (
	input  wire                clk,
	input  wire                en,
	input  wire signed [16:0]  y,
	input  wire signed [16:0]  x,
	output logic signed [15:0] angle
);
	localparam int N = rme_pkg::NSteps;
	rme_pkg::cordic_t st_s [N+1];
	logic signed [rme_pkg::ZW-1:0] zr;
	logic signed [rme_pkg::ZW-1:0] rnd;

	always_ff @(posedge clk) begin
		if (en) begin
			st_s[0].zero <= (x == 0) && (y == 0);
			if (x < 0) begin
				st_s[0].cx <= -(rme_pkg::CW'(x) <<< 14);
				st_s[0].cy <= -(rme_pkg::CW'(y) <<< 14);
				st_s[0].z  <= (y >= 0) ? rme_pkg::AngPiQ28 : -rme_pkg::AngPiQ28;
			end else begin
				st_s[0].cx <= rme_pkg::CW'(x) <<< 14;
				st_s[0].cy <= rme_pkg::CW'(y) <<< 14;
				st_s[0].z  <= '0;
			end
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				st_s[i+1].zero <= st_s[i].zero;
				if (!st_s[i].cy[rme_pkg::CW-1]) begin
					st_s[i+1].cx <= st_s[i].cx + (st_s[i].cy >>> i);
					st_s[i+1].cy <= st_s[i].cy - (st_s[i].cx >>> i);
					st_s[i+1].z  <= st_s[i].z + rme_pkg::atan_step(i);
				end else begin
					st_s[i+1].cx <= st_s[i].cx - (st_s[i].cy >>> i);
					st_s[i+1].cy <= st_s[i].cy + (st_s[i].cx >>> i);
					st_s[i+1].z  <= st_s[i].z - rme_pkg::atan_step(i);
				end
			end
		end
	end

	always_comb begin
		zr  = st_s[N].z + 32'sd16384;
		rnd = zr >>> 15;
		if (st_s[N].zero)
			angle = '0;
		else if (rnd > 32'(rme_pkg::PiQ13))
			angle = rme_pkg::PiQ13;
		else if (rnd < -32'(rme_pkg::PiQ13))
			angle = -rme_pkg::PiQ13;
		else
			angle = rnd[15:0];
	end
endmodule
`default_nettype wire

// ----- rtl/rotation_matrix_to_euler.sv -----
// ---------------------------------------------------------------------------
// rotation_matrix_to_euler
// Euler angles from the used elements of a rotation matrix, pole detection.
// ---------------------------------------------------------------------------
// channel   direction  contents
// s_axis    in         tdata: mat_e0,e2,e4,e5,e6,e8,e10 (16 bit each)
// m_axis    out        tdata: angle_x, angle_y, angle_z, pole_case
// cfg       in         pole_threshold (15 bit)
// One item per cycle while the output is not stalled; the data passes the input
// stage, sqrt pipeline, CORDIC pipeline of NSteps + 1 stages and output register.
// The whole pipeline advances when the output register is empty or taken.
// Reset clears valid bits and sets pole_threshold to 16351.
`timescale 1ns / 1ps
`default_nettype none
module rotation_matrix_to_euler (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire [111:0] s_axis_tdata,  // e0, e2, e4, e5, e6, e8, e10
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [55:0] m_axis_tdata,  // angle_x, angle_y, angle_z, pole_case, zero pad
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [14:0] cfg_data
);
`include "assert_macros.svh"
	localparam int SQ = rme_pkg::SqrtSteps;
	localparam int LAT = 1 + SQ + 1 + rme_pkg::NSteps + 1;

	logic [14:0] thr_q;
	logic        en;
	logic [LAT-1:0] vld_s;

	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= rme_pkg::ThrReset;
		end else if (cfg_valid) begin
			thr_q <= cfg_data;
		end
	end

	// stage 1: register inputs, pole decision, e4 squared
	logic signed [15:0] e4i;
	logic signed [31:0] sq;
	logic signed [33:0] dd;
	assign e4i = s_axis_tdata[47:32];
	assign sq = e4i * e4i;
	assign dd = 34'sd268435456 - 34'(sq);

	// square root pipeline: one result bit per stage, restoring method
	logic [29:0] rem_s [SQ+1];
	logic [14:0] root_s [SQ+1];
	logic signed [15:0] p0_s [SQ+1], p2_s [SQ+1], p4_s [SQ+1], p5_s [SQ+1];
	logic signed [15:0] p6_s [SQ+1], p8_s [SQ+1], p10_s [SQ+1];
	rme_pkg::pole_t pp_s [SQ+1];

	always_ff @(posedge clk) begin
		if (en) begin
			p0_s[0]   <= s_axis_tdata[15:0];
			p2_s[0]   <= s_axis_tdata[31:16];
			p4_s[0]   <= e4i;
			p5_s[0]   <= s_axis_tdata[63:48];
			p6_s[0]   <= s_axis_tdata[79:64];
			p8_s[0]   <= s_axis_tdata[95:80];
			p10_s[0]  <= s_axis_tdata[111:96];
			rem_s[0]  <= dd[33] ? '0 : 30'(dd[28:0]);
			root_s[0] <= '0;
			if (17'(e4i) > $signed({2'b0, thr_q}))
				pp_s[0] <= rme_pkg::POLE_NORTH;
			else if (17'(e4i) < -$signed({2'b0, thr_q}))
				pp_s[0] <= rme_pkg::POLE_SOUTH;
			else
				pp_s[0] <= rme_pkg::POLE_NONE;
		end
	end

	for (genvar k = 0; k < SQ; k++) begin : g_sqrt
		localparam int B = SQ - 1 - k;
		logic [29:0] trial;
		assign trial = (30'(root_s[k]) << (B + 1)) + (30'd1 << (2 * B));
		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_s[k] >= trial) begin
					rem_s[k+1]  <= rem_s[k] - trial;
					root_s[k+1] <= root_s[k] | (15'd1 << B);
				end else begin
					rem_s[k+1]  <= rem_s[k];
					root_s[k+1] <= root_s[k];
				end
				p0_s[k+1] <= p0_s[k]; p2_s[k+1] <= p2_s[k]; p4_s[k+1] <= p4_s[k];
				p5_s[k+1] <= p5_s[k]; p6_s[k+1] <= p6_s[k]; p8_s[k+1] <= p8_s[k];
				p10_s[k+1] <= p10_s[k]; pp_s[k+1] <= pp_s[k];
			end
		end
	end

	// select CORDIC operands
	logic signed [16:0] ya, xa, yb, xb, yc, xc;
	logic pole_any;
	assign pole_any = pp_s[SQ] != rme_pkg::POLE_NONE;
	assign ya = pole_any ? 17'(p2_s[SQ]) : -17'(p8_s[SQ]);
	assign xa = pole_any ? 17'(p10_s[SQ]) : 17'(p0_s[SQ]);
	assign yb = -17'(p6_s[SQ]);
	assign xb = 17'(p5_s[SQ]);
	assign yc = 17'(p4_s[SQ]);
	assign xc = $signed({1'b0, 1'b0, root_s[SQ]});

	localparam int CL = rme_pkg::NSteps + 1;
	rme_pkg::pole_t pc_s [CL];
	always_ff @(posedge clk) begin
		if (en) begin
			pc_s[0] <= pp_s[SQ];
		end
	end
	for (genvar j = 1; j < CL; j++) begin : g_pd
		always_ff @(posedge clk) begin
			if (en) begin
				pc_s[j] <= pc_s[j-1];
			end
		end
	end

	logic signed [15:0] ang_a, ang_b, ang_c;
	rme_cordic u_cy (.clk(clk), .en(en), .y(ya), .x(xa), .angle(ang_a));
	rme_cordic u_cz (.clk(clk), .en(en), .y(yb), .x(xb), .angle(ang_b));
	rme_cordic u_cx (.clk(clk), .en(en), .y(yc), .x(xc), .angle(ang_c));

	rme_pkg::pole_t pf;
	assign pf = pc_s[CL-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAT-2:0], s_axis_tvalid};
		end
	end
	assign m_axis_tvalid = vld_s[LAT-1];

	always_ff @(posedge clk) begin
		if (en) begin
			m_axis_tdata[31:16] <= ang_a;
			m_axis_tdata[55:50] <= '0;
			m_axis_tdata[49:48] <= pf;
			unique case (pf)
				rme_pkg::POLE_NORTH: begin
					m_axis_tdata[15:0]  <= rme_pkg::HalfPiQ13;
					m_axis_tdata[47:32] <= '0;
				end
				rme_pkg::POLE_SOUTH: begin
					m_axis_tdata[15:0]  <= -rme_pkg::HalfPiQ13;
					m_axis_tdata[47:32] <= '0;
				end
				default: begin
					m_axis_tdata[15:0]  <= ang_c;
					m_axis_tdata[47:32] <= ang_b;
				end
			endcase
		end
	end

	`ASSERT_IMPL(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
	`ASSERT_IMPL(a_pole, clk, arst_n, m_axis_tvalid |-> m_axis_tdata[49:48] <= rme_pkg::POLE_SOUTH)
	`ASSERT_IMPL(a_zpole, clk, arst_n, m_axis_tvalid && m_axis_tdata[49:48] != rme_pkg::POLE_NONE |-> m_axis_tdata[47:32] == '0)
endmodule
`default_nettype wire
